// ----- rtl/core/rotor_speed_supply_report_defines.svh -----
// Assertion macros for the rotor speed and supply report RTL.
// Included by modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef ROTOR_SPEED_SUPPLY_REPORT_DEFINES_SVH
`define ROTOR_SPEED_SUPPLY_REPORT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RSSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RSSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rssr_pkg.sv -----
// Package for the rotor speed and supply report block: widths, constants,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package rssr_pkg;

	localparam int NUM_PERIODS = 5;
	localparam int IDX_W       = 3;
	localparam int QUO_W       = 25;   // 24000000 fits in 25 bits
	localparam int CNT_W       = 5;

	localparam logic [QUO_W-1:0] TICK_HZ    = 25'd24000000;
	localparam logic [CNT_W-1:0] DIV_LAST   = 5'd24;      // QUO_W steps, counted from zero
	localparam logic [IDX_W-1:0] LAST_IDX   = 3'd4;
	localparam logic [14:0]      FREQ_MAX   = 15'd32767;
	localparam logic [18:0]      GEAR_NUM   = 19'd11;     // 22/56 reduced to 11/28
	localparam logic [34:0]      RECIP7     = 35'd149797; // ceil(2^20/7)
	localparam logic [31:0]      RECIP5     = 32'd52429;  // ceil(2^18/5)
	localparam logic [17:0]      SUPPLY_MUL = 18'd125;
	localparam logic [24:0]      TEMP_MUL   = 25'd4300;

	localparam logic [7:0]  RST_INTERVAL  = 8'd1;
	localparam logic [13:0] RST_LIMIT     = 14'd500;
	localparam logic [12:0] RST_THRESHOLD = 13'd3200;

	typedef enum logic [1:0] {
		REG_INTERVAL  = 2'd0,
		REG_LIMIT     = 2'd1,
		REG_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic             capture;
		logic             div_start;
		logic             scale;
		logic             accum;
		logic             mean;
		logic             load_out;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rssr_div.sv -----
// Radix-2 restoring divider: TICK_HZ / divisor, one quotient bit per cycle.
// Depends on rssr_pkg.
`default_nettype none

module rssr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [31:0]                divisor,
	output logic      [rssr_pkg::QUO_W-1:0] quotient,
	output logic                            done
);
	import rssr_pkg::*;

	logic [31:0]      rem_q;
	logic [31:0]      dsr_q;
	logic [QUO_W-1:0] dvd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			dvd_q <= TICK_HZ;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[QUO_W-2:0], ge};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/rssr_dp.sv -----
// Datapath: input capture, supply/temperature scaling, per-period speed,
// sum, gradient, mean and output registers. Depends on rssr_pkg, rssr_div.
`default_nettype none

module rssr_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rssr_pkg::cmd_t       cmd,
	output rssr_pkg::status_t         status,
	input  wire logic [13:0]          speed_limit,
	input  wire logic [12:0]          supply_threshold_mv,
	input  wire logic [10:0]          battery_raw,
	input  wire logic [11:0]          temp_code,
	input  wire logic [31:0]          period_a,
	input  wire logic [31:0]          period_b,
	input  wire logic [31:0]          period_c,
	input  wire logic [31:0]          period_d,
	input  wire logic [31:0]          period_e,
	output logic      [12:0]          supply_mv,
	output logic      [12:0]          temp_mv,
	output logic      [13:0]          speed_mean,
	output logic signed [16:0]        speed_gradient,
	output logic                      overspeed,
	output logic                      period_fault
);
	import rssr_pkg::*;

	logic [31:0]        per_q [NUM_PERIODS];
	logic [12:0]        supply_q;
	logic [12:0]        temp_q;
	logic [16:0]        x_q;
	logic [15:0]        sum_q;
	logic signed [16:0] grad_q;
	logic               fault_q;
	logic [13:0]        mean_q;

	logic [17:0]      supply_prod;
	logic [24:0]      temp_prod;
	logic [31:0]      cur_per;
	logic [QUO_W-1:0] quo;
	logic             div_done;
	logic             per_zero;
	logic [14:0]      f_sat;
	logic [18:0]      gear_prod;
	logic [34:0]      w_prod;
	logic [13:0]      w;
	logic signed [16:0] w_s;
	logic signed [16:0] grad_term;
	logic [31:0]      mean_prod;

	assign supply_prod = 18'(battery_raw) * SUPPLY_MUL;
	assign temp_prod   = 25'(temp_code) * TEMP_MUL;

	assign cur_per = per_q[cmd.idx];

	rssr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (cur_per),
		.quotient (quo),
		.done     (div_done)
	);

	assign status.div_done = div_done;

	// zero period reads as frequency 0; fast shafts clamp at FREQ_MAX
	assign per_zero  = cur_per == '0;
	assign f_sat     = per_zero ? '0 : ((quo > QUO_W'(FREQ_MAX)) ? FREQ_MAX : quo[14:0]);
	assign gear_prod = 19'(f_sat) * GEAR_NUM;

	// floor(x/7) by reciprocal, exact for x below 2^17
	assign w_prod    = 35'(x_q) * RECIP7;
	assign w         = w_prod[33:20];
	assign w_s       = signed'(17'(w));

	always_comb begin
		case (cmd.idx)
			3'd0:    grad_term = -(w_s <<< 1);
			3'd1:    grad_term = -w_s;
			3'd3:    grad_term = w_s;
			3'd4:    grad_term = w_s <<< 1;
			default: grad_term = '0;
		endcase
	end

	assign mean_prod = 32'(sum_q) * RECIP5;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			per_q[0] <= period_a;
			per_q[1] <= period_b;
			per_q[2] <= period_c;
			per_q[3] <= period_d;
			per_q[4] <= period_e;
			supply_q <= supply_prod[17:5];
			temp_q   <= temp_prod[24:12];
			sum_q    <= '0;
			grad_q   <= '0;
			fault_q  <= 1'b0;
		end
		if (cmd.scale) begin
			x_q <= gear_prod[18:2];
			if (per_zero)
				fault_q <= 1'b1;
		end
		if (cmd.accum) begin
			sum_q  <= sum_q + 16'(w);
			grad_q <= grad_q + grad_term;
		end
		if (cmd.mean)
			mean_q <= mean_prod[31:18];
		if (cmd.load_out) begin
			supply_mv      <= supply_q;
			temp_mv        <= temp_q;
			speed_mean     <= mean_q;
			speed_gradient <= grad_q;
			overspeed      <= (mean_q >= speed_limit) && (supply_q > supply_threshold_mv);
			period_fault   <= fault_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rssr_ctrl.sv -----
// Controller: alert counter, input/output handshake and the sequence that
// steps the datapath through five periods. Depends on rssr_pkg and the defines header.
`default_nettype none
`include "rotor_speed_supply_report_defines.svh"

module rssr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic [7:0]        report_interval,
	input  wire rssr_pkg::status_t status,
	output rssr_pkg::cmd_t         cmd
);
	import rssr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_SCALE,
		S_ACCUM,
		S_MEAN,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       alert_q;
	logic             out_valid_q;

	logic [7:0] alert_inc;
	logic       hit;
	logic       in_xfer;
	logic       out_free;

	// counter climbs no higher than the interval; a count already above it holds
	assign alert_inc = (alert_q < report_interval) ? 8'(alert_q + 1'b1) : alert_q;
	assign hit       = alert_inc == report_interval;
	assign in_stall  = state_q != S_IDLE;
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.idx       = idx_q;
		cmd.capture   = in_xfer && hit;
		cmd.div_start = state_q == S_START;
		cmd.scale     = state_q == S_SCALE;
		cmd.accum     = state_q == S_ACCUM;
		cmd.mean      = state_q == S_MEAN;
		cmd.load_out  = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			alert_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.load_out)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						alert_q <= hit ? '0 : alert_inc;
						if (hit) begin
							idx_q   <= '0;
							state_q <= S_START;
						end
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (status.div_done)
						state_q <= S_SCALE;
				end
				S_SCALE: state_q <= S_ACCUM;
				S_ACCUM: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_MEAN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_START;
					end
				end
				S_MEAN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RSSR_ASSERT_NOW(a_load_no_overwrite, cmd.load_out, !(out_valid_q && out_stall), "report overwrote a held result")
	`RSSR_ASSERT_NOW(a_done_in_wait, status.div_done, state_q == S_WAIT, "divider finished outside wait state")
	`RSSR_ASSERT_NOW(a_idx_range, state_q != S_IDLE, idx_q <= LAST_IDX, "period index out of range")
	`RSSR_ASSERT_NEXT(a_capture_starts, cmd.capture, state_q == S_START && idx_q == '0, "capture did not start the first division")

endmodule

`default_nettype wire

// ----- rtl/core/rotor_speed_supply_report.sv -----
// Rotor speed and supply report. An alert that does not complete the report
// interval is taken while the block is idle and gives no result. A reporting
// alert steps through five periods, each a division start, a radix-2 division
// in one shared divider, scaling and accumulation; then mean and output load.
// The next alert is taken once the report is in the output register.
// Reset (arst_n low, asynchronous): counter cleared, registers to 1/500/3200.
`default_nettype none

module rotor_speed_supply_report (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [13:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [10:0] battery_raw,
	input  wire logic [11:0] temp_code,
	input  wire logic [31:0] period_a,
	input  wire logic [31:0] period_b,
	input  wire logic [31:0] period_c,
	input  wire logic [31:0] period_d,
	input  wire logic [31:0] period_e,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [12:0]      supply_mv,
	output logic [12:0]      temp_mv,
	output logic [13:0]      speed_mean,
	output logic signed [16:0] speed_gradient,
	output logic             overspeed,
	output logic             period_fault
);
	import rssr_pkg::*;

	logic [7:0]  interval_q;
	logic [13:0] limit_q;
	logic [12:0] threshold_q;

	cmd_t    cmd;
	status_t status;

	// index 3 is not a register and is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= RST_INTERVAL;
			limit_q     <= RST_LIMIT;
			threshold_q <= RST_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL:  interval_q  <= cfg_data[7:0];
				REG_LIMIT:     limit_q     <= cfg_data;
				REG_THRESHOLD: threshold_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	rssr_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.report_interval (interval_q),
		.status          (status),
		.cmd             (cmd)
	);

	rssr_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.speed_limit         (limit_q),
		.supply_threshold_mv (threshold_q),
		.battery_raw         (battery_raw),
		.temp_code           (temp_code),
		.period_a            (period_a),
		.period_b            (period_b),
		.period_c            (period_c),
		.period_d            (period_d),
		.period_e            (period_e),
		.supply_mv           (supply_mv),
		.temp_mv             (temp_mv),
		.speed_mean          (speed_mean),
		.speed_gradient      (speed_gradient),
		.overspeed           (overspeed),
		.period_fault        (period_fault)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for rotor_speed_supply_report: drives alerts, predicts the
// report stream from its own model of the interval counter and speed math, checks outputs.
// Depends on rssr_pkg and the rotor_speed_supply_report RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rssr_pkg::*;

	localparam int DRAIN_CYCLES = 200;   // covers a reporting alert with margin
	localparam int IDLE_LIMIT   = 5000;

	typedef struct packed {
		logic [10:0]      battery;
		logic [11:0]      temp;
		logic [4:0][31:0] per;
	} alert_t;

	typedef struct packed {
		logic [12:0] supply;
		logic [12:0] temp;
		logic [13:0] mean;
		logic [16:0] grad;
		logic        over;
		logic        fault;
	} report_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	reg_idx_t    cfg_index;
	logic [13:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [10:0] battery_raw;
	logic [11:0] temp_code;
	logic [31:0] period_a, period_b, period_c, period_d, period_e;
	logic        out_valid;
	logic        out_stall;
	logic [12:0] supply_mv;
	logic [12:0] temp_mv;
	logic [13:0] speed_mean;
	logic signed [16:0] speed_gradient;
	logic        overspeed;
	logic        period_fault;

	// predictor state
	logic [7:0]  alert_tally;
	logic [7:0]  cfg_interval;
	logic [13:0] cfg_limit;
	logic [12:0] cfg_threshold;
	report_t     pending_reports[$];
	report_t     want;

	int fail_count     = 0;
	int max_send_gap   = 9;
	int max_recv_stall = 9;
	int stall_left     = 0;
	int idle_cycles    = 0;

	rotor_speed_supply_report u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.battery_raw(battery_raw),
		.temp_code(temp_code),
		.period_a(period_a),
		.period_b(period_b),
		.period_c(period_c),
		.period_d(period_d),
		.period_e(period_e),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.supply_mv(supply_mv),
		.temp_mv(temp_mv),
		.speed_mean(speed_mean),
		.speed_gradient(speed_gradient),
		.overspeed(overspeed),
		.period_fault(period_fault)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [13:0] shaft_speed(input logic [31:0] per, inout logic fault);
		logic [31:0] freq;
		if (per == 32'd0) begin
			fault = 1'b1;
			return 14'd0;
		end
		freq = 32'd24000000 / per;
		if (freq > 32'd32767)
			freq = 32'd32767;
		return 14'((freq * 32'd22) / 32'd56);
	endfunction

	function automatic report_t predict_report(input alert_t a);
		report_t     r;
		logic [31:0] speed[5];
		logic [31:0] total;
		int          g;
		logic        fault;
		fault = 1'b0;
		total = '0;
		r.supply = 13'((32'(a.battery) * 32'd125) >> 5);
		r.temp   = 13'((32'(a.temp) * 32'd4300) / 32'd4096);
		for (int i = 0; i < 5; i++) begin
			speed[i] = 32'(shaft_speed(a.per[i], fault));
			total += speed[i];
		end
		r.mean  = 14'(total / 32'd5);
		g = -2 * int'(speed[0]) - int'(speed[1]) + int'(speed[3]) + 2 * int'(speed[4]);
		r.grad  = g[16:0];
		r.over  = (r.mean >= cfg_limit) && (r.supply > cfg_threshold);
		r.fault = fault;
		return r;
	endfunction

	function automatic alert_t alert_of(input logic [10:0] b, input logic [11:0] t,
			input logic [31:0] pa, input logic [31:0] pb, input logic [31:0] pc,
			input logic [31:0] pd, input logic [31:0] pe);
		alert_t a;
		a.battery = b;
		a.temp    = t;
		a.per     = {pe, pd, pc, pb, pa};
		return a;
	endfunction

	function automatic logic [31:0] rand_period();
		case ($urandom_range(0, 19))
			0:             return 32'd0;
			1:             return 32'hFFFF_FFFF;
			2, 3, 4:       return $urandom_range(1, 732);     // saturating range
			5, 6, 7, 8, 9,
			10, 11, 12:    return $urandom_range(733, 60000);
			default:       return $urandom;
		endcase
	endfunction

	function automatic alert_t rand_alert();
		return alert_of(11'($urandom_range(0, 2047)), 12'($urandom_range(0, 4095)),
			rand_period(), rand_period(), rand_period(), rand_period(), rand_period());
	endfunction

	// one alert transfer, then advance the predictor
	task automatic send_alert(input alert_t a);
		int gap;
		gap = $urandom_range(0, max_send_gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		battery_raw <= a.battery;
		temp_code   <= a.temp;
		period_a    <= a.per[0];
		period_b    <= a.per[1];
		period_c    <= a.per[2];
		period_d    <= a.per[3];
		period_e    <= a.per[4];
		do @(posedge clk); while (in_stall);
		if (alert_tally < cfg_interval)
			alert_tally++;
		if (alert_tally == cfg_interval) begin
			alert_tally = 8'd0;
			pending_reports.push_back(predict_report(a));
		end
	endtask

	// drop valid, drain reports, then give a non-reporting alert time to finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [13:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_INTERVAL:  cfg_interval  = val[7:0];
			REG_LIMIT:     cfg_limit     = val;
			REG_THRESHOLD: cfg_threshold = val[12:0];
			default:       ;
		endcase
	endtask

	task automatic check_field(input string name, input logic signed [31:0] expv,
			input logic signed [31:0] actv);
		if (expv !== actv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("report transfer with no report pending");
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("supply_mv", 32'(want.supply), 32'(supply_mv));
				check_field("temp_mv", 32'(want.temp), 32'(temp_mv));
				check_field("speed_mean", 32'(want.mean), 32'(speed_mean));
				check_field("speed_gradient", 32'($signed(want.grad)), 32'(speed_gradient));
				check_field("overspeed", 32'(want.over), 32'(overspeed));
				check_field("period_fault", 32'(want.fault), 32'(period_fault));
			end
			stall_left = $urandom_range(0, max_recv_stall);
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// reset values: interval 1, limit 500, threshold 3200
	task automatic test_reset_defaults();
		send_alert(alert_of(11'd2047, 12'd4095, 12000, 12000, 12000, 12000, 12000));
		send_alert(alert_of(11'd819, 12'd0, 12000, 12000, 12000, 12000, 12000));
		send_alert(alert_of(11'd820, 12'd2048, 24000, 24000, 24000, 24000, 24000));
	endtask

	task automatic test_field_extremes();
		send_alert(alert_of(11'd0, 12'd0, 0, 0, 0, 0, 0));
		send_alert(alert_of(11'd2047, 12'd4095, 1, 1, 1, 1, 1));
		send_alert(alert_of(11'd1024, 12'd1, 732, 733, 734, 32'hFFFF_FFFF, 32'h8000_0000));
		// gradient at both ends
		send_alert(alert_of(11'd3, 12'd4094, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5000, 1, 1));
		send_alert(alert_of(11'd1365, 12'd2730, 1, 1, 5000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_alert(alert_of(11'd5, 12'd7, 1000, 2000, 3000, 4000, 0));
	endtask

	task automatic test_overspeed_edges();
		settle();
		write_reg(REG_LIMIT, 14'd785);
		write_reg(REG_THRESHOLD, 14'd3202);
		send_alert(alert_of(11'd820, 12'd100, 12000, 12000, 12000, 12000, 12000));
		settle();
		write_reg(REG_THRESHOLD, 14'd3203);
		send_alert(alert_of(11'd820, 12'd100, 12000, 12000, 12000, 12000, 12000));
		settle();
		write_reg(REG_LIMIT, 14'd786);
		write_reg(REG_THRESHOLD, 14'd0);
		send_alert(alert_of(11'd2047, 12'd100, 12000, 12000, 12000, 12000, 12000));
		settle();
		write_reg(REG_LIMIT, 14'd0);
		send_alert(alert_of(11'd0, 12'd0, 0, 0, 0, 0, 0));
		send_alert(alert_of(11'd1, 12'd0, 0, 0, 0, 0, 0));
		settle();
		write_reg(REG_LIMIT, 14'd16383);
		write_reg(REG_THRESHOLD, 14'd8191);
		send_alert(alert_of(11'd2047, 12'd4095, 1, 1, 1, 1, 1));
	endtask

	task automatic test_interval_zero();
		settle();
		write_reg(REG_INTERVAL, 14'd0);
		repeat (3) send_alert(rand_alert());
	endtask

	// count left above a lowered interval holds reports off until raised to the count
	task automatic test_interval_lowered();
		settle();
		write_reg(REG_INTERVAL, 14'd5);
		repeat (3) send_alert(rand_alert());
		settle();
		write_reg(REG_INTERVAL, 14'd2);
		repeat (3) send_alert(rand_alert());
		settle();
		write_reg(REG_INTERVAL, 14'd3);
		send_alert(rand_alert());
		settle();
		write_reg(REG_INTERVAL, 14'd1);
	endtask

	task automatic test_max_interval();
		settle();
		write_reg(REG_INTERVAL, 14'd255);
		repeat (255) send_alert(rand_alert());
	endtask

	task automatic test_random();
		logic [7:0]  ivl;
		logic [13:0] lim;
		logic [12:0] thr;
		for (int phase = 0; phase < 8; phase++) begin
			settle();
			ivl = 8'($urandom_range(0, 6));
			if (ivl < alert_tally)
				ivl = alert_tally;
			case ($urandom_range(0, 5))
				0:       lim = 14'd0;
				1:       lim = 14'd16383;
				default: lim = 14'($urandom_range(0, 8000));
			endcase
			case ($urandom_range(0, 5))
				0:       thr = 13'd0;
				1:       thr = 13'd8191;
				default: thr = 13'($urandom_range(0, 8191));
			endcase
			write_reg(REG_INTERVAL, 14'(ivl));
			write_reg(REG_LIMIT, lim);
			write_reg(REG_THRESHOLD, 14'(thr));
			max_send_gap   = (phase % 3 == 2) ? 0 : 9;
			max_recv_stall = (phase % 4 == 3) ? 0 : 9;
			repeat (15) send_alert(rand_alert());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_INTERVAL;
		cfg_data      = 14'd0;
		in_valid      = 1'b0;
		battery_raw   = 11'd0;
		temp_code     = 12'd0;
		period_a      = 32'd0;
		period_b      = 32'd0;
		period_c      = 32'd0;
		period_d      = 32'd0;
		period_e      = 32'd0;
		out_stall     = 1'b0;
		alert_tally   = 8'd0;
		cfg_interval  = RST_INTERVAL;
		cfg_limit     = RST_LIMIT;
		cfg_threshold = RST_THRESHOLD;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_overspeed_edges();
		test_interval_zero();
		test_interval_lowered();
		test_max_interval();
		test_random();
		settle();

		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rssr_pkg.sv
rtl/core/rssr_div.sv
rtl/core/rssr_dp.sv
rtl/core/rssr_ctrl.sv
rtl/core/rotor_speed_supply_report.sv
tb/tb_top.sv
